// File: sv/tpn_pkg.sv
// shared types, byte codes and the byte classifier for the punctuation normalizer
// no dependencies

package tpn_pkg;

   localparam logic [7:0] CH_COMMA   = 8'h2C;
   localparam logic [7:0] CH_BANG    = 8'h21;
   localparam logic [7:0] CH_QUEST   = 8'h3F;
   localparam logic [7:0] CH_COLON   = 8'h3A;
   localparam logic [7:0] CH_LPAREN  = 8'h28;
   localparam logic [7:0] CH_RPAREN  = 8'h29;
   localparam logic [7:0] CH_LT      = 8'h3C;
   localparam logic [7:0] CH_GT      = 8'h3E;
   localparam logic [7:0] CH_LBRACK  = 8'h5B;
   localparam logic [7:0] CH_RBRACK  = 8'h5D;
   localparam logic [7:0] CH_APOS    = 8'h27;
   localparam logic [7:0] CH_DQUOTE  = 8'h22;
   localparam logic [7:0] CH_SEMI    = 8'h3B;
   localparam logic [7:0] CH_DASH    = 8'h2D;
   localparam logic [7:0] CH_SLASH   = 8'h2F;
   localparam logic [7:0] CH_BSLASH  = 8'h5C;
   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_PERIOD  = 8'h2E;
   localparam logic [7:0] CH_NUL     = 8'h00;

   typedef enum logic [1:0] {
      CLS_DROP,
      CLS_SPACE,
      CLS_DOT,
      CLS_PASS
   } char_class_type;

   // one result transfer on the output channel
   typedef struct packed {
      logic [7:0] out_char;
      logic       out_valid;
      logic       doc_end;
      logic       run_last;
   } rsp_item_type;

   // handshake between the core and the result register
   typedef struct packed {
      logic issue;
      logic can_load;
   } rsp_ctrl_type;

   function automatic char_class_type classify(input logic [7:0] ch);
      char_class_type cls;
      case (ch) inside
         CH_COMMA, CH_BANG, CH_QUEST, CH_COLON, CH_LPAREN, CH_RPAREN,
         CH_LT, CH_GT, CH_LBRACK, CH_RBRACK, CH_APOS, CH_DQUOTE: cls = CLS_DROP;
         CH_SEMI, CH_DASH, CH_SLASH, CH_BSLASH, CH_NEWLINE, CH_TAB,
         CH_SPACE:                                              cls = CLS_SPACE;
         CH_PERIOD:                                             cls = CLS_DOT;
         default:                                               cls = CLS_PASS;
      endcase
      return cls;
   endfunction

endpackage

// File: sv/tpn_input.sv
// input register stage of the punctuation normalizer
// self-contained, no package needed

module tpn_input (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,
   input  logic       req_tlast,
   input  logic       item_done,
   output logic       item_valid,
   output logic [7:0] item_ch,
   output logic       item_last
);

   logic       valid_ff, valid_in;
   logic [7:0] ch_ff;
   logic       last_ff;
   logic       take;

   assign req_tready = !valid_ff || item_done;
   assign take       = req_tvalid && req_tready;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (item_done) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         ch_ff   <= req_tdata;
         last_ff <= req_tlast;
      end
   end

   assign item_valid = valid_ff;
   assign item_ch    = ch_ff;
   assign item_last  = last_ff;

endmodule

// File: sv/tpn_core.sv
// document flags, byte decode and result sequencing of the punctuation normalizer
// depends on tpn_pkg

module tpn_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  item_valid,
   input  logic [7:0]            item_ch,
   input  logic                  item_last,
   output logic                  item_done,
   output tpn_pkg::rsp_ctrl_type ctrl_out,
   input  logic                  can_load,
   output tpn_pkg::rsp_item_type rsp_item
);
   import tpn_pkg::*;

   logic dot_pending_ff, dot_pending_in;
   logic nonempty_ff, nonempty_in;
   logic last_space_ff, last_space_in;
   logic phase_ff, phase_in;

   char_class_type cls;
   logic       dot_emit;
   logic       ne_after_dot;
   logic       lws_after_dot;
   logic       cur_emit;
   logic [7:0] cur_char;
   logic       empty_end;
   logic [1:0] nres;
   logic       issue;
   logic       final_one;
   logic       sel_second;

   always_comb begin
      cls           = classify(item_ch);
      dot_emit      = dot_pending_ff && (item_ch != CH_SPACE) && (item_ch != CH_NEWLINE);
      ne_after_dot  = nonempty_ff || dot_emit;
      lws_after_dot = dot_emit ? 1'b0 : last_space_ff;
      cur_emit      = 1'b0;
      cur_char      = item_ch;
      case (cls)
         CLS_SPACE: begin
            cur_emit = ne_after_dot && !lws_after_dot;
            cur_char = CH_SPACE;
         end
         CLS_PASS:  cur_emit = 1'b1;
         default:   cur_emit = 1'b0;
      endcase
      empty_end = item_last && !dot_emit && !cur_emit;
      nres      = {1'b0, dot_emit} + {1'b0, cur_emit} + {1'b0, empty_end};
   end

   // one result goes out per cycle while the result register can load; phase marks the second of a pair
   always_comb begin
      issue      = item_valid && (nres != 2'd0) && can_load;
      final_one  = (phase_ff == 1'b1) || (nres == 2'd1);
      item_done  = item_valid && ((nres == 2'd0) || (issue && final_one));
      sel_second = phase_ff;

      rsp_item.doc_end  = item_last && final_one;
      rsp_item.run_last = final_one;
      if (empty_end) begin
         rsp_item.out_char  = CH_NUL;
         rsp_item.out_valid = 1'b0;
      end else if (dot_emit && !sel_second) begin
         rsp_item.out_char  = CH_PERIOD;
         rsp_item.out_valid = 1'b1;
      end else begin
         rsp_item.out_char  = cur_char;
         rsp_item.out_valid = 1'b1;
      end

      ctrl_out.issue    = issue;
      ctrl_out.can_load = can_load;
   end

   always_comb begin
      phase_in       = phase_ff;
      dot_pending_in = dot_pending_ff;
      nonempty_in    = nonempty_ff;
      last_space_in  = last_space_ff;
      if (item_done) begin
         phase_in = 1'b0;
         if (item_last) begin
            dot_pending_in = 1'b0;
            nonempty_in    = 1'b0;
            last_space_in  = 1'b0;
         end else begin
            dot_pending_in = (cls == CLS_DOT);
            nonempty_in    = ne_after_dot || cur_emit;
            last_space_in  = cur_emit ? (cls == CLS_SPACE) : lws_after_dot;
         end
      end else if (issue) begin
         phase_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= 1'b0;
         dot_pending_ff <= 1'b0;
         nonempty_ff    <= 1'b0;
         last_space_ff  <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         dot_pending_ff <= dot_pending_in;
         nonempty_ff    <= nonempty_in;
         last_space_ff  <= last_space_in;
      end
   end

endmodule

// File: sv/tpn_output.sv
// result register of the punctuation normalizer, drives the rsp channel
// depends on tpn_pkg

module tpn_output (
   input  logic                  clock,
   input  logic                  reset,
   input  tpn_pkg::rsp_ctrl_type ctrl_in,
   input  tpn_pkg::rsp_item_type rsp_item,
   output logic                  can_load,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [7:0]            rsp_tdata,
   output logic [1:0]            rsp_tuser,
   output logic                  rsp_tlast
);
   import tpn_pkg::*;

   logic         valid_ff, valid_in;
   rsp_item_type item_ff;

   assign can_load = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      if (ctrl_in.issue && ctrl_in.can_load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl_in.issue && ctrl_in.can_load) begin
         item_ff <= rsp_item;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = item_ff.out_char;
   assign rsp_tuser  = {item_ff.run_last, item_ff.out_valid};
   assign rsp_tlast  = item_ff.doc_end;

endmodule

// File: sv/text_punctuation_normalizer_top.sv
// path: input register, core decode, then the result register that drives rsp
// throughput: one byte per cycle when it gives at most one result and rsp does not stall;
//   a held period released ahead of a byte that emits as well makes a pair of results,
//   as the single result register passes one result transfer per cycle
// reset: synchronous, clears the stage valid bits, the pair phase and the document flags
// depends on tpn_pkg, tpn_input, tpn_core, tpn_output

module text_punctuation_normalizer_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] ch
   input  logic       req_tlast,   // doc_last
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_char
   output logic [1:0] rsp_tuser,   // [0] out_valid, [1] run_last
   output logic       rsp_tlast    // doc_end
);
   import tpn_pkg::*;

   logic         item_valid;
   logic [7:0]   item_ch;
   logic         item_last;
   logic         item_done;
   logic         can_load;
   rsp_ctrl_type ctrl;
   rsp_item_type rsp_item;

   tpn_input u_input (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .item_done  (item_done),
      .item_valid (item_valid),
      .item_ch    (item_ch),
      .item_last  (item_last)
   );

   tpn_core u_core (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item_ch    (item_ch),
      .item_last  (item_last),
      .item_done  (item_done),
      .ctrl_out   (ctrl),
      .can_load   (can_load),
      .rsp_item   (rsp_item)
   );

   tpn_output u_output (
      .clock      (clock),
      .reset      (reset),
      .ctrl_in    (ctrl),
      .rsp_item   (rsp_item),
      .can_load   (can_load),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
